/* rtl/core/pi_current_loop_with_modes_top_defines.svh */
// ----------------------------------------------------------------------------
// PI current loop assertion macros
// Shared concurrent assertion forms, clocked on clk and reset by rst_n.
// ----------------------------------------------------------------------------
`ifndef PI_CURRENT_LOOP_WITH_MODES_TOP_DEFINES_SVH
`define PI_CURRENT_LOOP_WITH_MODES_TOP_DEFINES_SVH

// same-cycle implication
`define PICL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PICL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/picl_pkg.sv */
// ----------------------------------------------------------------------------
// PI current loop package
// Widths, command and register codes, and the per-word stage tag.
// ----------------------------------------------------------------------------
package picl_pkg;

  localparam int TEST_POINTS    = 100;
  localparam int GAIN_FRAC_BITS = 8;

  localparam int CMD_W   = 2;
  localparam int CUR_W   = 13;
  localparam int PCT_W   = 7;
  localparam int GAIN_W  = 16;
  localparam int DUTY_W  = 16;
  localparam int AMP_W   = 12;
  localparam int STEP_W  = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam int E_W     = CUR_W + 1;
  localparam int SUM_W   = 32;
  localparam int SUMX_W  = SUM_W + 1;
  localparam int P_W     = GAIN_W + 1 + E_W;
  localparam int Q_W     = GAIN_W + 1 + SUM_W;
  localparam int MAG_W   = Q_W - 1;
  localparam int SH_W    = MAG_W - GAIN_FRAC_BITS;
  localparam int OPEN_W  = 12;

  localparam logic [OPEN_W-1:0] OPEN_LOOP_SCALE = OPEN_W'(24);
  localparam logic [STEP_W-1:0] TEST_END = STEP_W'(TEST_POINTS - 1);

  localparam logic [STEP_W-1:0] WAVE_A_LO = STEP_W'(0);
  localparam logic [STEP_W-1:0] WAVE_A_HI = STEP_W'(25);
  localparam logic [STEP_W-1:0] WAVE_B_LO = STEP_W'(50);
  localparam logic [STEP_W-1:0] WAVE_B_HI = STEP_W'(75);

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  localparam logic [CMD_W-1:0] CMD_IDLE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_OPEN   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TEST   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLOSED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_MAX   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_AMP   = 2'd3;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = '0;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = '0;
  localparam logic [DUTY_W-1:0] DUTY_MAX_RST   = DUTY_W'(2400);
  localparam logic [AMP_W-1:0]  WAVE_AMP_RST   = AMP_W'(200);

  typedef struct packed {
    logic              done;
    logic [STEP_W-1:0] sidx;
    logic              svalid;
    logic              dir;
    logic [OPEN_W-1:0] open_duty;
  } tag_t;

endpackage

/* rtl/core/pi_current_loop_with_modes_top.sv */
// ----------------------------------------------------------------------------
// PI current loop with modes
// Idle, open-loop, square-wave test and closed-loop PI current control,
// one word per control tick, in a four-register pipeline.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake            payload
//   in       in   in_valid/in_ready    command, measured, reference, percent
//   out      out  out_valid/out_ready  duty, direction, done, index, valid
//   cfg      in   cfg_we               cfg_index, cfg_wdata
//
// One word per cycle sustained unless out_ready stalls; words pass stages 0, 1, 2, out.
// Integrator, test counter and direction update in the first stage, so the
// next word sees them at once. Each stage holds while its successor is full
// and stalled; bubbles collapse. Reset is synchronous, with no clearing pass.
//
`include "pi_current_loop_with_modes_top_defines.svh"

module pi_current_loop_with_modes_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [picl_pkg::CMD_W-1:0]            in_command,
  input  logic signed [picl_pkg::CUR_W-1:0]     in_measured_current,
  input  logic signed [picl_pkg::CUR_W-1:0]     in_reference_current,
  input  logic [picl_pkg::PCT_W-1:0]            in_pwm_percent,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [picl_pkg::DUTY_W-1:0]           out_duty_count,
  output logic                                  out_direction,
  output logic                                  out_test_done,
  output logic [picl_pkg::STEP_W-1:0]           out_sample_index,
  output logic                                  out_sample_valid,
  input  logic                                  cfg_we,
  input  logic [picl_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [picl_pkg::CFG_DAT_W-1:0]        cfg_wdata
);

  logic [picl_pkg::GAIN_W-1:0] prop_gain_r;
  logic [picl_pkg::GAIN_W-1:0] integ_gain_r;
  logic [picl_pkg::DUTY_W-1:0] duty_max_r;
  logic [picl_pkg::AMP_W-1:0]  wave_amp_r;

  logic signed [picl_pkg::SUM_W-1:0] error_sum_r;
  logic [picl_pkg::STEP_W-1:0]       test_step_r;
  logic                              dir_latch_r;

  logic                               v0_r, v1_r, v2_r, out_valid_r;
  logic                               rdy1, rdy2, rdy3, mv01;
  logic [picl_pkg::CMD_W-1:0]         cmd0_r;
  logic signed [picl_pkg::CUR_W-1:0]  meas0_r;
  logic signed [picl_pkg::CUR_W-1:0]  ref0_r;
  logic [picl_pkg::PCT_W-1:0]         pct0_r;

  logic signed [picl_pkg::E_W-1:0]    e1_r;
  logic signed [picl_pkg::SUM_W-1:0]  sum1_r;
  picl_pkg::tag_t                     tag1_r;

  logic signed [picl_pkg::P_W-1:0]    p2_r;
  logic signed [picl_pkg::Q_W-1:0]    q2_r;
  picl_pkg::tag_t                     tag2_r;

  logic [picl_pkg::DUTY_W-1:0]        duty_r;
  logic                               dir_r, done_r, svalid_r;
  logic [picl_pkg::STEP_W-1:0]        sidx_r;

  // stage 0 to 1
  logic [picl_pkg::STEP_W-1:0]        step_inc;
  logic                               test_end, run_pi, is_test;
  logic signed [picl_pkg::CUR_W-1:0]  amp_s, wave, pi_ref;
  logic signed [picl_pkg::E_W-1:0]    e_nxt;
  logic signed [picl_pkg::SUMX_W-1:0] sum_wide;
  logic signed [picl_pkg::SUM_W-1:0]  sum_nxt;
  logic                               dir_nxt;
  logic [picl_pkg::STEP_W-1:0]        step_nxt;
  picl_pkg::tag_t                     tag_nxt;

  // stage 1 to 2
  logic signed [picl_pkg::P_W-1:0]    p_nxt;
  logic signed [picl_pkg::Q_W-1:0]    q_nxt;

  // stage 2 to out
  logic signed [picl_pkg::Q_W-1:0]    acc;
  logic [picl_pkg::MAG_W-1:0]         mag;
  logic [picl_pkg::SH_W-1:0]          mag_sh;
  logic [picl_pkg::DUTY_W-1:0]        pi_duty, duty_nxt;

  assign rdy3     = !out_valid_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = !v0_r || rdy1;
  assign mv01     = v0_r && rdy1;

  always_comb begin
    is_test  = (cmd0_r == picl_pkg::CMD_TEST);
    step_inc = test_step_r + picl_pkg::STEP_W'(1);
    test_end = (step_inc >= picl_pkg::TEST_END);
    amp_s    = $signed({1'b0, wave_amp_r});
    if (step_inc inside {[picl_pkg::WAVE_A_LO:picl_pkg::WAVE_A_HI],
                         [picl_pkg::WAVE_B_LO:picl_pkg::WAVE_B_HI]}) begin
      wave = amp_s;
    end else begin
      wave = -amp_s;
    end
    pi_ref   = is_test ? wave : ref0_r;
    run_pi   = (cmd0_r == picl_pkg::CMD_CLOSED) || (is_test && !test_end);
    e_nxt    = picl_pkg::E_W'(pi_ref) - picl_pkg::E_W'(meas0_r);
    sum_wide = picl_pkg::SUMX_W'(error_sum_r) + picl_pkg::SUMX_W'(e_nxt);
    if (sum_wide[picl_pkg::SUMX_W-1] != sum_wide[picl_pkg::SUM_W-1]) begin
      sum_nxt = sum_wide[picl_pkg::SUMX_W-1] ? picl_pkg::SUM_MIN : picl_pkg::SUM_MAX;
    end else begin
      sum_nxt = sum_wide[picl_pkg::SUM_W-1:0];
    end
    dir_nxt = dir_latch_r;
    if (run_pi && pi_ref != '0) begin
      dir_nxt = pi_ref[picl_pkg::CUR_W-1];
    end
    step_nxt = test_step_r;
    if (is_test) begin
      step_nxt = test_end ? '0 : step_inc;
    end
    tag_nxt.done      = is_test && test_end;
    tag_nxt.svalid    = run_pi;
    tag_nxt.dir       = dir_nxt;
    tag_nxt.sidx      = run_pi ? (is_test ? step_inc : test_step_r) : '0;
    tag_nxt.open_duty = '0;
    if (cmd0_r == picl_pkg::CMD_OPEN) begin
      tag_nxt.open_duty = picl_pkg::OPEN_W'(pct0_r) * picl_pkg::OPEN_LOOP_SCALE;
    end
  end

  always_comb begin
    p_nxt = picl_pkg::P_W'($signed({1'b0, prop_gain_r})) * picl_pkg::P_W'(e1_r);
    q_nxt = picl_pkg::Q_W'($signed({1'b0, integ_gain_r})) * picl_pkg::Q_W'(sum1_r);
  end

  always_comb begin
    acc = picl_pkg::Q_W'(p2_r) + q2_r;
    if (acc[picl_pkg::Q_W-1]) begin
      mag = picl_pkg::MAG_W'(-acc);
    end else begin
      mag = picl_pkg::MAG_W'(acc);
    end
    mag_sh = mag[picl_pkg::MAG_W-1:picl_pkg::GAIN_FRAC_BITS];
    if (mag_sh >= picl_pkg::SH_W'(duty_max_r)) begin
      pi_duty = duty_max_r;
    end else begin
      pi_duty = mag_sh[picl_pkg::DUTY_W-1:0];
    end
    duty_nxt = tag2_r.svalid ? pi_duty : picl_pkg::DUTY_W'(tag2_r.open_duty);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= picl_pkg::PROP_GAIN_RST;
      integ_gain_r <= picl_pkg::INTEG_GAIN_RST;
      duty_max_r   <= picl_pkg::DUTY_MAX_RST;
      wave_amp_r   <= picl_pkg::WAVE_AMP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        picl_pkg::CFG_PROP_GAIN:  prop_gain_r  <= cfg_wdata[picl_pkg::GAIN_W-1:0];
        picl_pkg::CFG_INTEG_GAIN: integ_gain_r <= cfg_wdata[picl_pkg::GAIN_W-1:0];
        picl_pkg::CFG_DUTY_MAX:   duty_max_r   <= cfg_wdata[picl_pkg::DUTY_W-1:0];
        picl_pkg::CFG_WAVE_AMP:   wave_amp_r   <= cfg_wdata[picl_pkg::AMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_sum_r <= '0;
      test_step_r <= '0;
      dir_latch_r <= 1'b0;
    end else if (mv01) begin
      test_step_r <= step_nxt;
      dir_latch_r <= dir_nxt;
      if (run_pi) begin
        error_sum_r <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        v0_r <= in_valid;
      end
      if (rdy1) begin
        v1_r <= v0_r;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        out_valid_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cmd0_r  <= in_command;
      meas0_r <= in_measured_current;
      ref0_r  <= in_reference_current;
      pct0_r  <= in_pwm_percent;
    end
    if (mv01) begin
      e1_r   <= e_nxt;
      sum1_r <= sum_nxt;
      tag1_r <= tag_nxt;
    end
    if (v1_r && rdy2) begin
      p2_r   <= p_nxt;
      q2_r   <= q_nxt;
      tag2_r <= tag1_r;
    end
    if (v2_r && rdy3) begin
      duty_r   <= duty_nxt;
      dir_r    <= tag2_r.dir;
      done_r   <= tag2_r.done;
      sidx_r   <= tag2_r.sidx;
      svalid_r <= tag2_r.svalid;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_duty_count   = duty_r;
  assign out_direction    = dir_r;
  assign out_test_done    = done_r;
  assign out_sample_index = sidx_r;
  assign out_sample_valid = svalid_r;

  `PICL_ASSERT_NEXT(a_accept_fills, in_valid && in_ready, v0_r, "accepted word not held")
  `PICL_ASSERT_NOW(a_step_range, 1'b1, test_step_r < picl_pkg::TEST_END,
                   "test counter past end")
  `PICL_ASSERT_NOW(a_done_quiet, out_valid && out_test_done,
                   out_duty_count == '0 && !out_sample_valid, "done word not quiet")
  `PICL_ASSERT_NOW(a_duty_clamp, out_valid && out_sample_valid,
                   out_duty_count <= duty_max_r, "PI duty above clamp")

endmodule

/* tb/pi_current_loop_with_modes_top_tb.sv */
// ----------------------------------------------------------------------------
// PI current loop with modes: testbench
// Sends control ticks through the valid/ready input channel and compares
// every result word against a cycle-free predictor of the idle, open-loop,
// square-wave test and closed-loop PI modes. Register settings change between
// phases. Both sides idle in random bursts, except in the last phase, which
// runs back to back.
// ----------------------------------------------------------------------------
module pi_current_loop_with_modes_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import picl_pkg::*;

  localparam logic signed [CUR_W-1:0] CUR_MAX = {1'b0, {(CUR_W-1){1'b1}}};
  localparam logic signed [CUR_W-1:0] CUR_MIN = {1'b1, {(CUR_W-1){1'b0}}};

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic signed [CUR_W-1:0] measured;
    logic signed [CUR_W-1:0] target;
    logic [PCT_W-1:0]        percent;
  } tick_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              dir;
    logic              done;
    logic [STEP_W-1:0] sidx;
    logic              svalid;
  } ctrl_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CMD_W-1:0] in_command = '0;
  logic signed [CUR_W-1:0] in_measured_current = '0;
  logic signed [CUR_W-1:0] in_reference_current = '0;
  logic [PCT_W-1:0] in_pwm_percent = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [DUTY_W-1:0] out_duty_count;
  logic out_direction;
  logic out_test_done;
  logic [STEP_W-1:0] out_sample_index;
  logic out_sample_valid;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;

  pi_current_loop_with_modes_top DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_command           (in_command),
    .in_measured_current  (in_measured_current),
    .in_reference_current (in_reference_current),
    .in_pwm_percent       (in_pwm_percent),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_duty_count       (out_duty_count),
    .out_direction        (out_direction),
    .out_test_done        (out_test_done),
    .out_sample_index     (out_sample_index),
    .out_sample_valid     (out_sample_valid),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  always #5 clk = ~clk;

  logic [GAIN_W-1:0]       m_prop  = PROP_GAIN_RST;
  logic [GAIN_W-1:0]       m_integ = INTEG_GAIN_RST;
  logic [DUTY_W-1:0]       m_dmax  = DUTY_MAX_RST;
  logic [AMP_W-1:0]        m_amp   = WAVE_AMP_RST;
  logic signed [SUM_W-1:0] m_sum   = '0;
  logic [STEP_W-1:0]       m_step  = '0;
  logic                    m_dir   = 1'b0;

  tick_t     tick_q[$];
  ctrl_out_t results_due[$];
  tick_t     cur_tick;
  ctrl_out_t due;
  bit        holding = 1'b0;
  bit        calm = 1'b0;
  int        src_gap = 0;
  int        snk_gap = 0;
  int        src_pct = 0;
  int        snk_pct = 0;
  int        pushed = 0;
  int        fails = 0;
  int        pace [4] = '{0, 5, 20, 50};

  function automatic logic signed [CUR_W-1:0] wave_level(input logic [STEP_W-1:0] i);
    logic signed [CUR_W-1:0] a;
    a = {1'b0, m_amp};
    if (i <= WAVE_A_HI || (i >= WAVE_B_LO && i <= WAVE_B_HI)) return a;
    return -a;
  endfunction

  function automatic logic [DUTY_W-1:0] pi_law(input logic signed [CUR_W-1:0] tgt,
                                               input logic signed [CUR_W-1:0] meas);
    longint e, s, acc, mag;
    e = longint'(tgt) - longint'(meas);
    s = longint'(m_sum) + e;
    if (s > longint'(SUM_MAX)) s = longint'(SUM_MAX);
    if (s < longint'(SUM_MIN)) s = longint'(SUM_MIN);
    m_sum = s[SUM_W-1:0];
    if (tgt > 0) m_dir = 1'b0;
    else if (tgt < 0) m_dir = 1'b1;
    acc = longint'(m_prop) * e + longint'(m_integ) * longint'(m_sum);
    mag = (acc < 0) ? -acc : acc;
    mag = mag >> GAIN_FRAC_BITS;
    if (mag >= longint'(m_dmax)) mag = longint'(m_dmax);
    return mag[DUTY_W-1:0];
  endfunction

  function automatic ctrl_out_t control_tick(input tick_t w);
    ctrl_out_t r;
    r = '0;
    case (w.command)
      CMD_OPEN: begin
        r.duty = DUTY_W'(w.percent * OPEN_LOOP_SCALE);
      end
      CMD_TEST: begin
        m_step = m_step + 1'b1;
        if (m_step >= TEST_END) begin
          m_step = '0;
          r.done = 1'b1;
        end else begin
          r.duty = pi_law(wave_level(m_step), w.measured);
          r.sidx = m_step;
          r.svalid = 1'b1;
        end
      end
      CMD_CLOSED: begin
        r.duty = pi_law(w.target, w.measured);
        r.sidx = m_step;
        r.svalid = 1'b1;
      end
      default: ;
    endcase
    r.dir = m_dir;
    return r;
  endfunction

  task automatic flag(input string msg);
    if (fails < 50) $display("mismatch: %s", msg);
    fails++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        results_due.push_back(control_tick(cur_tick));
        holding = 1'b0;
      end
      if (!holding) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          cur_tick = tick_q.pop_front();
          holding = 1'b1;
          in_valid <= 1'b1;
          in_command <= cur_tick.command;
          in_measured_current <= cur_tick.measured;
          in_reference_current <= cur_tick.target;
          in_pwm_percent <= cur_tick.percent;
          if (!calm && $urandom_range(0, 99) < src_pct) src_gap = $urandom_range(1, 13);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          flag($sformatf("unexpected word, duty_count %0d", out_duty_count));
        end else begin
          due = results_due.pop_front();
          if (out_duty_count !== due.duty)
            flag($sformatf("duty_count got %0d want %0d", out_duty_count, due.duty));
          if (out_direction !== due.dir)
            flag($sformatf("direction got %0b want %0b", out_direction, due.dir));
          if (out_test_done !== due.done)
            flag($sformatf("test_done got %0b want %0b", out_test_done, due.done));
          if (out_sample_index !== due.sidx)
            flag($sformatf("sample_index got %0d want %0d", out_sample_index, due.sidx));
          if (out_sample_valid !== due.svalid)
            flag($sformatf("sample_valid got %0b want %0b", out_sample_valid, due.svalid));
        end
      end
      if (snk_gap > 0) begin
        snk_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 99) < snk_pct) snk_gap = $urandom_range(1, 13);
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_PROP_GAIN:  m_prop = val;
      CFG_INTEG_GAIN: m_integ = val;
      CFG_DUTY_MAX:   m_dmax = val;
      CFG_WAVE_AMP:   m_amp = val[AMP_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    while (tick_q.size() != 0 || holding || results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_setting(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
                              input logic [DUTY_W-1:0] d, input logic [AMP_W-1:0] a);
    settle();
    write_reg(CFG_PROP_GAIN, p);
    write_reg(CFG_INTEG_GAIN, i);
    write_reg(CFG_DUTY_MAX, d);
    write_reg(CFG_WAVE_AMP, CFG_DAT_W'(a));
  endtask

  task automatic push_word(input logic [CMD_W-1:0] c, input logic signed [CUR_W-1:0] m,
                           input logic signed [CUR_W-1:0] t, input logic [PCT_W-1:0] p);
    tick_t w;
    while (tick_q.size() >= 32) @(posedge clk);
    w.command = c;
    w.measured = m;
    w.target = t;
    w.percent = p;
    tick_q.push_back(w);
    pushed++;
  endtask

  function automatic logic signed [CUR_W-1:0] rand_cur(input int span);
    logic signed [CUR_W-1:0] v;
    if (span <= 0) v = CUR_W'($urandom_range(0, 8191));
    else v = CUR_W'(int'($urandom_range(0, 2 * span)) - span);
    return v;
  endfunction

  function automatic logic [PCT_W-1:0] rand_pct();
    if ($urandom_range(0, 3) == 0) return PCT_W'($urandom_range(0, 127));
    return PCT_W'($urandom_range(0, 100));
  endfunction

  task automatic random_burst();
    int kind, len, k, span;
    logic signed [CUR_W-1:0] t;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(95, 110);
        span = (m_amp > 3900) ? 0 : int'(m_amp) + 150;
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 19) == 0)
            push_word(CMD_W'($urandom_range(0, 3)), rand_cur(0), rand_cur(0), rand_pct());
          else
            push_word(CMD_TEST, ($urandom_range(0, 4) == 0) ? rand_cur(0) : rand_cur(span),
                      rand_cur(0), rand_pct());
        end
      end
      4, 5: begin
        len = $urandom_range(1, 20);
        t = rand_cur(500);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 3) == 0)
            t = ($urandom_range(0, 2) == 0) ? '0 : (($urandom_range(0, 1) == 0) ?
                                                    rand_cur(0) : rand_cur(500));
          push_word(CMD_CLOSED, ($urandom_range(0, 1) == 0) ? rand_cur(0) : rand_cur(600),
                    t, rand_pct());
        end
      end
      6: begin
        len = $urandom_range(1, 5);
        for (k = 0; k < len; k++) push_word(CMD_OPEN, rand_cur(0), rand_cur(0), rand_pct());
      end
      7: begin
        len = $urandom_range(1, 3);
        for (k = 0; k < len; k++) push_word(CMD_IDLE, rand_cur(0), rand_cur(0), rand_pct());
      end
      default: begin
        len = $urandom_range(1, 8);
        for (k = 0; k < len; k++)
          push_word(CMD_W'($urandom_range(0, 3)), rand_cur(0), rand_cur(0),
                    PCT_W'($urandom_range(0, 127)));
      end
    endcase
  endtask

  initial begin
    int p;
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    push_word(CMD_IDLE, CUR_MIN, CUR_MAX, 7'd127);
    push_word(CMD_OPEN, '0, '0, 7'd100);
    push_word(CMD_TEST, '0, '0, '0);
    push_word(CMD_CLOSED, CUR_MIN, CUR_MAX, '0);

    load_setting(16'd256, 16'd16, 16'd2400, 12'd200);
    push_word(CMD_OPEN, CUR_MAX, CUR_MIN, 7'd0);
    push_word(CMD_OPEN, '0, '0, 7'd1);
    push_word(CMD_OPEN, '0, '0, 7'd100);
    push_word(CMD_OPEN, '0, '0, 7'd127);
    push_word(CMD_CLOSED, CUR_MIN, CUR_MAX, '0);
    push_word(CMD_CLOSED, CUR_MAX, CUR_MIN, '0);
    push_word(CMD_CLOSED, '0, '0, '0);
    push_word(CMD_CLOSED, 13'sd100, '0, '0);
    push_word(CMD_CLOSED, '0, 13'sd1, '0);
    push_word(CMD_CLOSED, '0, -13'sd1, '0);
    push_word(CMD_IDLE, CUR_MAX, CUR_MAX, 7'd127);
    push_word(CMD_TEST, CUR_MIN, '0, '0);
    push_word(CMD_TEST, CUR_MAX, '0, '0);
    push_word(CMD_TEST, '0, '0, '0);
    push_word(CMD_TEST, 13'sd150, '0, '0);
    push_word(CMD_CLOSED, 13'sd20, 13'sd40, '0);
    push_word(CMD_IDLE, '0, '0, '0);
    push_word(CMD_TEST, -13'sd150, '0, '0);

    for (p = 0; p < 7; p++) begin
      case (p)
        0: load_setting(16'd256, 16'd16, 16'd2400, 12'd200);
        1: load_setting('0, '0, '0, '0);
        2: load_setting('1, '1, '1, '1);
        default: load_setting(GAIN_W'($urandom_range(0, 1024)), GAIN_W'($urandom_range(0, 64)),
                              DUTY_W'($urandom_range(0, 65535)),
                              AMP_W'($urandom_range(0, 4095)));
      endcase
      src_pct = pace[$urandom_range(0, 3)];
      snk_pct = pace[$urandom_range(0, 3)];
      calm = (p == 6);
      pushed = 0;
      while (pushed < 150) random_burst();
    end

    settle();
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* pi_current_loop_with_modes_top.f */
+incdir+rtl/core
rtl/core/picl_pkg.sv
rtl/core/pi_current_loop_with_modes_top.sv
tb/pi_current_loop_with_modes_top_tb.sv
